// ===== src/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon test unit.
// ----------------------------------------------------------------------------
package pip_pkg;

  // default sizing
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 32;

  // fixed field widths
  localparam int CountW = 5;
  localparam int IndexW = 4;
  localparam int FieldW = 32;

  // command codes
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [IndexW-1:0]        vertex_index;
    logic signed [FieldW-1:0] coord_x;
    logic signed [FieldW-1:0] coord_y;
  } pip_in_t;

  typedef struct packed {
    logic inside_res;
    logic on_vertex;
  } pip_out_t;

  // tag that travels with an edge through the crossing pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } pip_tag_t;

  // crossing pipeline result
  typedef struct packed {
    logic valid;
    logic last;
    logic toggle;
  } pip_flag_t;

endpackage

// ===== src/point_in_polygon_test_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// Even-odd ray casting against one stored polygon held in vertex memory.
// ----------------------------------------------------------------------------
//  channel | direction | signals                        | payload
//  in      | input     | in_valid_i / in_stall_o        | pip_in_t (load or query)
//  out     | output    | out_valid_o / out_stall_i      | pip_out_t (one per query)
//  cfg     | input     | cfg_we_i / cfg_wdata_i         | vertex_count
//
//  a vertex load does not leave the idle state, so the block stays free.
//  a query reads the n stored vertices in turn, n the saturated vertex count,
//  then passes through the registered read, the closing edge, the three
//  crossing stages and the output load.
//  a zero count skips the reads and goes straight to the output load.
//  reset clears the count and control state; vertex memory is not cleared.
//  a query result waits in the output register, a new transaction is taken
//  meanwhile; the next query only finishes once that result has gone.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit #(
  parameter int MaxVertices = pip_pkg::MAX_VERTICES_DEF,
  parameter int CoordBits   = pip_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pip_pkg::CountW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pip_pkg::pip_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pip_pkg::pip_out_t          out_data_o
);
  import pip_pkg::*;

  localparam int AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CW = $clog2(MaxVertices + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] vertex_count_q;
  logic [CW-1:0]     n_q, n_sat;
  logic [AW-1:0]     cnt_q;
  logic [CW-1:0]     last_idx;
  logic              cnt_at_last;

  logic signed [CoordBits-1:0] mem_x [MaxVertices];
  logic signed [CoordBits-1:0] mem_y [MaxVertices];
  logic signed [CoordBits-1:0] rd_x_q, rd_y_q;
  logic signed [CoordBits-1:0] in_x, in_y;
  logic signed [CoordBits-1:0] px_q, py_q;
  logic signed [CoordBits-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
  logic signed [CoordBits-1:0] edge_bx, edge_by;

  logic in_acc, wr_en, rd_en, in_range, query_acc, out_load;
  logic rvalid_q, rfirst_q, rlast_q, close_q;
  logic hit_q, inside_q;

  pip_tag_t  edge_tag;
  pip_flag_t xres;
  pip_out_t  out_q;
  logic      out_valid_q;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(in_data_i.vertex_index) < 32'(MaxVertices));
  assign wr_en      = in_acc && (in_data_i.command == CmdLoad) && in_range;
  assign query_acc  = in_acc && (in_data_i.command == CmdQuery);
  assign in_x       = $signed(in_data_i.coord_x[CoordBits-1:0]);
  assign in_y       = $signed(in_data_i.coord_y[CoordBits-1:0]);

  always_comb begin
    if (32'(vertex_count_q) > 32'(MaxVertices)) begin
      n_sat = CW'(MaxVertices);
    end else begin
      n_sat = CW'(vertex_count_q);
    end
  end

  assign last_idx    = n_q - CW'(1);
  assign cnt_at_last = (CW'(cnt_q) == last_idx);
  assign rd_en       = (state_q == StRead);
  assign out_load    = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (query_acc) begin
          state_d = (n_sat == '0) ? StDone : StRead;
        end
      end
      StRead: begin
        if (cnt_at_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (xres.valid && xres.last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // vertex memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[AW'(in_data_i.vertex_index)] <= in_x;
      mem_y[AW'(in_data_i.vertex_index)] <= in_y;
    end
    if (rd_en) begin
      rd_x_q <= mem_x[cnt_q];
      rd_y_q <= mem_y[cnt_q];
    end
  end

  // closing edge runs from the last vertex back to the first
  assign edge_tag.valid = (rvalid_q && !rfirst_q) || close_q;
  assign edge_tag.last  = close_q;
  assign edge_bx        = close_q ? first_x_q : rd_x_q;
  assign edge_by        = close_q ? first_y_q : rd_y_q;

  pip_crossing #(
    .CoordBits(CoordBits)
  ) u_crossing (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tag_i (edge_tag),
    .ax_i  (prev_x_q),
    .ay_i  (prev_y_q),
    .bx_i  (edge_bx),
    .by_i  (edge_by),
    .px_i  (px_q),
    .py_i  (py_q),
    .res_o (xres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      vertex_count_q <= '0;
      n_q            <= '0;
      cnt_q          <= '0;
      rvalid_q       <= 1'b0;
      rfirst_q       <= 1'b0;
      rlast_q        <= 1'b0;
      close_q        <= 1'b0;
      hit_q          <= 1'b0;
      inside_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rd_en;
      rfirst_q <= rd_en && (cnt_q == '0);
      rlast_q  <= rd_en && cnt_at_last;
      close_q  <= rvalid_q && rlast_q;
      if (cfg_we_i) begin
        vertex_count_q <= cfg_wdata_i;
      end
      if (query_acc) begin
        n_q      <= n_sat;
        cnt_q    <= '0;
        hit_q    <= 1'b0;
        inside_q <= 1'b0;
      end else begin
        if (rd_en) begin
          cnt_q <= cnt_q + AW'(1);
        end
        if (rvalid_q && (rd_x_q == px_q) && (rd_y_q == py_q)) begin
          hit_q <= 1'b1;
        end
        if (xres.valid && xres.toggle) begin
          inside_q <= !inside_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      px_q <= in_x;
      py_q <= in_y;
    end
    if (rvalid_q) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
      if (rfirst_q) begin
        first_x_q <= rd_x_q;
        first_y_q <= rd_y_q;
      end
    end
    if (out_load) begin
      out_q.inside_res <= hit_q || inside_q;
      out_q.on_vertex  <= hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/pip_crossing.sv =====
// ----------------------------------------------------------------------------
// pip_crossing
// Three-stage edge crossing pipeline: differences, products, signed compare.
// ----------------------------------------------------------------------------
module pip_crossing #(
  parameter int CoordBits = pip_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pip_pkg::pip_tag_t           tag_i,
  input  logic signed [CoordBits-1:0] ax_i,
  input  logic signed [CoordBits-1:0] ay_i,
  input  logic signed [CoordBits-1:0] bx_i,
  input  logic signed [CoordBits-1:0] by_i,
  input  logic signed [CoordBits-1:0] px_i,
  input  logic signed [CoordBits-1:0] py_i,
  output pip_pkg::pip_flag_t          res_o
);
  import pip_pkg::*;

  localparam int DW = CoordBits + 1;
  localparam int PW = 2 * DW;

  pip_tag_t t1_q, t2_q;
  pip_flag_t res_q;

  logic signed [DW-1:0] dxp_d, dy_d, dxb_d, dyp_d;
  logic signed [DW-1:0] dxp_q, dy_q, dxb_q, dyp_q;
  logic                 cross_d, cross_q1, cross_q2;
  logic                 dyneg_q2;
  logic signed [PW-1:0] p1_q, p2_q;
  logic                 toggle_d;

  always_comb begin
    dxp_d   = DW'(px_i) - DW'(ax_i);
    dy_d    = DW'(by_i) - DW'(ay_i);
    dxb_d   = DW'(bx_i) - DW'(ax_i);
    dyp_d   = DW'(py_i) - DW'(ay_i);
    cross_d = (ay_i > py_i) != (by_i > py_i);
  end

  // crossing means dy is non-zero, so its sign picks the comparison
  always_comb begin
    if (dyneg_q2) begin
      toggle_d = cross_q2 && (p1_q > p2_q);
    end else begin
      toggle_d = cross_q2 && (p1_q < p2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q  <= '0;
      t2_q  <= '0;
      res_q <= '0;
    end else begin
      t1_q         <= tag_i;
      t2_q         <= t1_q;
      res_q.valid  <= t2_q.valid;
      res_q.last   <= t2_q.last;
      res_q.toggle <= toggle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dxp_q    <= dxp_d;
    dy_q     <= dy_d;
    dxb_q    <= dxb_d;
    dyp_q    <= dyp_d;
    cross_q1 <= cross_d;
    p1_q     <= PW'(dxp_q) * PW'(dy_q);
    p2_q     <= PW'(dxb_q) * PW'(dyp_q);
    cross_q2 <= cross_q1;
    dyneg_q2 <= dy_q[DW-1];
  end

  assign res_o = res_q;

endmodule

// ===== src/pip_checker.sv =====
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks for the point-in-polygon test unit, bound to the top.
// ----------------------------------------------------------------------------
module pip_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input pip_pkg::pip_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pip_pkg::pip_out_t out_data_o
);
  import pip_pkg::*;

  // a held result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a vertex load leaves the block free for the next transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == CmdLoad) |=> !in_stall_o)
    else $error("vertex load left the block busy");

  // a query keeps the block busy until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.command == CmdQuery) |=> in_stall_o)
    else $error("query accepted without going busy");

  // a new result only appears at the end of a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no query in progress");

  // a vertex hit always reports inside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.on_vertex |-> out_data_o.inside_res)
    else $error("vertex hit reported outside");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (.*);

// ===== dv/point_in_polygon_test_unit_tb.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit_tb
// Self-checking testbench for the point-in-polygon test unit. Vertex loads and
// point queries go in over the valid/stall input channel; loads update a local
// polygon model. Each query's expected verdict is queued, and every result
// transaction is checked against the oldest entry. Directed tests come first:
// zero count, a square, degenerate counts, a full table with extreme
// coordinates and saturated counts. Random polygon phases with random idling
// on both channels follow.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  localparam int MAX_V       = MAX_VERTICES_DEF;
  localparam int SETTLE      = 2 * MAX_V + 8;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [FieldW-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FieldW-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [FieldW-1:0] ONE   = 32'sh0001_0000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  pip_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pip_out_t          out_data_o;

  // polygon model
  logic signed [FieldW-1:0] poly_x [MAX_V];
  logic signed [FieldW-1:0] poly_y [MAX_V];
  logic [CountW-1:0]        poly_count;

  pip_out_t expected_verdicts [$];
  pip_out_t verdict_want;

  logic idle_en;
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   load_cnt;
  int   query_cnt;
  int   inside_cnt;
  int   vertex_hit_cnt;

  point_in_polygon_test_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = idle_en && ($urandom_range(0, 99) < 29);
  end

  // even-odd crossing count with exact cross-multiplied edge test
  function automatic pip_out_t classify_point(input logic signed [FieldW-1:0] px,
                                              input logic signed [FieldW-1:0] py);
    int                n;
    int                j;
    longint            qx, qy, ax, ay, bx, by, dy;
    logic signed [67:0] dx_p, dy_p, dx_e, dy_e, cross_val;
    logic              parity;
    logic              hit;
    pip_out_t          r;
    n      = (poly_count > MAX_V) ? MAX_V : int'(poly_count);
    qx     = px;
    qy     = py;
    parity = 1'b0;
    hit    = 1'b0;
    for (int i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      ax = poly_x[i];
      ay = poly_y[i];
      bx = poly_x[j];
      by = poly_y[j];
      if (qx == ax && qy == ay) hit = 1'b1;
      if ((ay > qy) != (by > qy)) begin
        dy        = by - ay;
        dx_p      = qx - ax;
        dy_p      = qy - ay;
        dx_e      = bx - ax;
        dy_e      = dy;
        cross_val = dx_p * dy_e - dx_e * dy_p;
        if ((dy > 0 && cross_val < 0) || (dy < 0 && cross_val > 0)) parity = !parity;
      end
    end
    r.inside_res = hit | parity;
    r.on_vertex  = hit;
    return r;
  endfunction

  task automatic send_item(input pip_in_t item);
    int       gap;
    pip_out_t want;
    if (idle_en && $urandom_range(0, 99) < 29) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = item;
    do @(posedge clk_i); while (in_stall_o);
    if (item.command == CmdLoad) begin
      poly_x[item.vertex_index] = item.coord_x;
      poly_y[item.vertex_index] = item.coord_y;
      load_cnt++;
    end else begin
      want = classify_point(item.coord_x, item.coord_y);
      expected_verdicts.insert(expected_verdicts.size(), want);
      query_cnt++;
      inside_cnt     += want.inside_res;
      vertex_hit_cnt += want.on_vertex;
    end
    @(negedge clk_i);
  endtask

  task automatic load_vertex(input int slot, input logic signed [FieldW-1:0] x,
                             input logic signed [FieldW-1:0] y);
    pip_in_t item;
    item.command      = CmdLoad;
    item.vertex_index = IndexW'(slot);
    item.coord_x      = x;
    item.coord_y      = y;
    send_item(item);
  endtask

  task automatic query_point(input logic signed [FieldW-1:0] x,
                             input logic signed [FieldW-1:0] y);
    pip_in_t item;
    item.command      = CmdQuery;
    item.vertex_index = IndexW'($urandom_range(0, MAX_V - 1));
    item.coord_x      = x;
    item.coord_y      = y;
    send_item(item);
  endtask

  // only called at a falling edge; waits until the block has gone quiet
  task automatic set_vertex_count(input logic [CountW-1:0] value);
    in_valid_i = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    poly_count = value;
  endtask

  function automatic logic signed [FieldW-1:0] rand_coord(input int scale);
    logic signed [FieldW-1:0] v;
    case (scale)
      0: begin
        v = $urandom_range(0, 16);
        return v - 8;
      end
      1: begin
        v = $urandom_range(0, 64);
        return (v - 32) <<< 16;
      end
      default: begin
        v = $urandom;
        return v;
      end
    endcase
  endfunction

  task automatic test_zero_count();
    query_point(C_MAX, C_MAX);
    set_vertex_count(5'd0);
    query_point(C_MIN, C_MIN);
  endtask

  task automatic test_square();
    load_vertex(0, -4 * ONE, -4 * ONE);
    load_vertex(1, 4 * ONE, -4 * ONE);
    load_vertex(2, 4 * ONE, 4 * ONE);
    load_vertex(3, -4 * ONE, 4 * ONE);
    set_vertex_count(5'd4);
    query_point(0, 0);
    query_point(5 * ONE, 0);
    query_point(4 * ONE, 4 * ONE);
    query_point(-4 * ONE, 0);
  endtask

  // one vertex closes on itself, two vertices give a flat edge
  task automatic test_degenerate_counts();
    set_vertex_count(5'd1);
    query_point(-4 * ONE, -4 * ONE);
    query_point(0, 0);
    set_vertex_count(5'd2);
    query_point(0, -4 * ONE);
  endtask

  task automatic test_full_table();
    for (int s = 4; s < MAX_V; s++) begin
      case (s % 4)
        0: load_vertex(s, C_MAX - s, C_MIN + s);
        1: load_vertex(s, C_MAX - s, C_MAX - s);
        2: load_vertex(s, C_MIN + s, C_MAX - s);
        default: load_vertex(s, C_MIN + s, C_MIN + s);
      endcase
    end
    set_vertex_count(5'd16);
    query_point(0, 0);
    query_point(poly_x[7], poly_y[7]);
    // counts past the table size saturate
    set_vertex_count(5'd31);
    query_point(C_MAX, C_MIN);
    set_vertex_count(5'd17);
    query_point(poly_x[15], poly_y[15]);
  endtask

  task automatic test_random_polygons();
    int cnt, n, scale, pick, off, nq, k;
    logic signed [FieldW-1:0] qx, qy;
    for (int phase = 0; phase < 8; phase++) begin
      // one phase runs with both sides flat out
      idle_en = (phase != 3);
      pick = $urandom_range(0, 9);
      if (pick == 0) cnt = $urandom_range(0, 2);
      else if (pick == 1) cnt = $urandom_range(17, 31);
      else cnt = $urandom_range(3, 16);
      n     = (cnt > MAX_V) ? MAX_V : cnt;
      scale = $urandom_range(0, 2);
      set_vertex_count(CountW'(cnt));
      off = $urandom_range(0, MAX_V - 1);
      for (int i = 0; i < n; i++)
        load_vertex((i + off) % n, rand_coord(scale), rand_coord(scale));
      nq = 50 - n;
      for (int q = 0; q < nq; q++) begin
        k = $urandom_range(0, 99);
        if (k < 8) begin
          // stray rewrite of a slot mid-phase
          load_vertex($urandom_range(0, MAX_V - 1), rand_coord(scale), rand_coord(scale));
        end else begin
          if (k < 28 && n > 0) begin
            pick = $urandom_range(0, n - 1);
            qx = poly_x[pick];
            qy = poly_y[pick];
          end else if (k < 42 && n > 0) begin
            qx = rand_coord(scale);
            qy = poly_y[$urandom_range(0, n - 1)];
          end else if (k < 52) begin
            qx = rand_coord(2);
            qy = rand_coord(2);
          end else begin
            qx = rand_coord(scale);
            qy = rand_coord(scale);
          end
          query_point(qx, qy);
        end
      end
    end
    idle_en = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result transaction: inside_res %0b on_vertex %0b",
               out_data_o.inside_res, out_data_o.on_vertex);
        err_cnt++;
      end else begin
        verdict_want = expected_verdicts.pop_front();
        if (out_data_o.inside_res !== verdict_want.inside_res) begin
          $error("inside_res: expected %0b, actual %0b",
                 verdict_want.inside_res, out_data_o.inside_res);
          err_cnt++;
        end
        if (out_data_o.on_vertex !== verdict_want.on_vertex) begin
          $error("on_vertex: expected %0b, actual %0b",
                 verdict_want.on_vertex, out_data_o.on_vertex);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    idle_en     = 1'b1;
    poly_count  = '0;
    load_cnt    = 0;
    query_cnt   = 0;
    inside_cnt  = 0;
    vertex_hit_cnt = 0;
    for (int i = 0; i < MAX_V; i++) begin
      poly_x[i] = '0;
      poly_y[i] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_zero_count();
    test_square();
    test_degenerate_counts();
    test_full_table();
    test_random_polygons();

    in_valid_i = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);

    $display("run covered %0d vertex loads and %0d point queries", load_cnt, query_cnt);
    $display("of the queries %0d were inside and %0d landed on a vertex",
             inside_cnt, vertex_hit_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
